// File: sv/pip_pkg.sv
// Shared types and constants for the point-in-polygon test block.
// No dependencies; imported by every module of the block.
`default_nettype none

package pip_pkg;

  localparam int PIP_MAX_VERTICES_DEF = 32;
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int HELD_W  = 6;
  localparam int ACT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEST   = 2'd2
  } pip_action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } pip_state_t;

  // Qualifier of the registered memory read word handed to the edge pipeline
  typedef struct packed {
    logic vld;
    logic seed;
  } pip_rd_t;

  // Status returned by the edge pipeline
  typedef struct packed {
    logic busy;
    logic flip;
  } pip_edge_stat_t;

endpackage

`default_nettype wire

// File: sv/pip_edge.sv
// Edge pipeline: takes one vertex per cycle from the memory read register and
// judges the edge to the previous vertex. Depends on pip_pkg.
`default_nettype none

module pip_edge
  import pip_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire pip_rd_t                   rd,
  input  wire logic signed [COORD_W-1:0] vtx_x,
  input  wire logic signed [COORD_W-1:0] vtx_y,
  input  wire logic signed [COORD_W-1:0] pt_x,
  input  wire logic signed [COORD_W-1:0] pt_y,
  output pip_edge_stat_t                 stat
);

  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;

  logic                      s1_vld_r, s1_vld_nxt;
  logic                      s1_strad_r, s1_strad_nxt;
  logic signed [DIFF_W-1:0]  s1_a_r, s1_a_nxt;     // px - xi
  logic signed [DIFF_W-1:0]  s1_dy_r, s1_dy_nxt;   // yj - yi
  logic signed [DIFF_W-1:0]  s1_b_r, s1_b_nxt;     // xj - xi
  logic signed [DIFF_W-1:0]  s1_c_r, s1_c_nxt;     // py - yi

  logic                      s2_vld_r, s2_vld_nxt;
  logic                      s2_strad_r;
  logic                      s2_dypos_r, s2_dypos_nxt;
  logic signed [PROD_W-1:0]  s2_lhs_r, s2_lhs_nxt;
  logic signed [PROD_W-1:0]  s2_rhs_r, s2_rhs_nxt;

  logic                      left;

  // Stage 1: differences and straddle test; the seed word only primes prev
  always_comb begin
    s1_vld_nxt   = rd.vld & ~rd.seed;
    s1_strad_nxt = (vtx_y >= pt_y) != (prev_y_r >= pt_y);
    s1_a_nxt     = DIFF_W'(pt_x) - DIFF_W'(vtx_x);
    s1_dy_nxt    = DIFF_W'(prev_y_r) - DIFF_W'(vtx_y);
    s1_b_nxt     = DIFF_W'(prev_x_r) - DIFF_W'(vtx_x);
    s1_c_nxt     = DIFF_W'(pt_y) - DIFF_W'(vtx_y);
  end

  // Stage 2: cross products
  always_comb begin
    s2_vld_nxt   = s1_vld_r;
    s2_dypos_nxt = s1_dy_r > DIFF_W'(0);
    s2_lhs_nxt   = s1_a_r * s1_dy_r;
    s2_rhs_nxt   = s1_b_r * s1_c_r;
  end

  // Stage 3: compare, sense flips with the sign of dy
  always_comb begin
    left      = s2_dypos_r ? (s2_lhs_r <= s2_rhs_r) : (s2_lhs_r >= s2_rhs_r);
    stat.flip = s2_vld_r & s2_strad_r & left;
    stat.busy = s1_vld_r | s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.vld) begin
      prev_x_r <= vtx_x;
      prev_y_r <= vtx_y;
    end
    s1_strad_r <= s1_strad_nxt;
    s1_a_r     <= s1_a_nxt;
    s1_dy_r    <= s1_dy_nxt;
    s1_b_r     <= s1_b_nxt;
    s1_c_r     <= s1_c_nxt;
    s2_strad_r <= s1_strad_r;
    s2_dypos_r <= s2_dypos_nxt;
    s2_lhs_r   <= s2_lhs_nxt;
    s2_rhs_r   <= s2_rhs_nxt;
  end

endmodule

`default_nettype wire

// File: sv/point_in_polygon_test.sv
// Top level of the crossing-number point-in-polygon test.
// Depends on pip_pkg and pip_edge.
//
// Usage
//   Input channel (in_valid/in_ready) carries one item: in_action selects
//   clear (drop all vertices and the overflow flag), append (store one
//   vertex) or test (judge the point in_coord_x/in_coord_y). Action 3 is
//   taken and ignored. Coordinates are signed Q15.8.
//   Result channel (out_valid/out_ready) carries one item per test only:
//   inside flag, sticky overflow flag and the vertex count at test time.
// Timing
//   Clear and append yield nothing. A test occupies the block while the
//   walk reads one vertex per cycle from the single-port-read vertex
//   memory, so the memory read port sets the rate, and then while a
//   three-stage edge pipeline drains. With no vertices a test skips the
//   walk and the drain and goes straight to its finish step. Items are
//   taken one at a time.
// Reset and stalls
//   Synchronous active-low reset empties the polygon and clears the overflow
//   flag; vertex memory contents are left as they are and never read unless
//   written. The result sits in an output register, so clears and appends are
//   still taken while out_ready is low; a further test waits in its finish
//   step until the previous result has gone.
`default_nettype none

module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = PIP_MAX_VERTICES_DEF
)(
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [ACT_W-1:0]          in_action,
  input  wire logic signed [COORD_W-1:0] in_coord_x,
  input  wire logic signed [COORD_W-1:0] in_coord_y,

  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_inside_res,
  output logic                           out_vertex_overflow,
  output logic [HELD_W-1:0]              out_vertices_held
);

  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int WORD_W = 2 * COORD_W;

  // Vertex memory: x in the upper half, y in the lower half of each word.
  // Writes happen only on an append while idle and reads only on a test's
  // seed read or during a walk, so the two never touch the same entry in the same cycle.
  logic [WORD_W-1:0] vtx_mem [MAX_VERTICES];
  logic [WORD_W-1:0] rd_data_r;

  pip_state_t                state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r;
  logic                      ovf_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic [ADDR_W-1:0]         idx_r;
  logic [ADDR_W-1:0]         last_r;
  logic                      inside_r;
  pip_rd_t                   rd_r;

  logic                      out_valid_r;
  logic                      out_inside_r;
  logic                      out_ovf_r;
  logic [HELD_W-1:0]         out_held_r;

  logic                      in_acc;
  logic                      is_clear, is_append, is_test;
  logic                      full;
  logic [ADDR_W-1:0]         seed_addr;
  logic                      rd_en, rd_seed;
  logic [ADDR_W-1:0]         rd_addr;
  logic                      out_load;
  pip_edge_stat_t            edge_stat;

  assign in_acc    = in_valid & in_ready;
  assign is_clear  = in_action == ACT_CLEAR;
  assign is_append = in_action == ACT_APPEND;
  assign is_test   = in_action == ACT_TEST;
  assign full      = cnt_r >= CNT_W'(MAX_VERTICES);
  // Seed the walk with the last vertex: it is the first edge's far end
  assign seed_addr = ADDR_W'(cnt_r - CNT_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && is_test) begin
          state_nxt = (cnt_r == '0) ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (idx_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_r.vld && !edge_stat.busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_seed  = 1'b0;
    rd_addr  = idx_r;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && is_test && cnt_r != '0) begin
          rd_en   = 1'b1;
          rd_seed = 1'b1;
          rd_addr = seed_addr;
        end
      end
      ST_WALK: begin
        rd_en = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        out_load = ~out_valid_r | out_ready;
      end
      default: begin
      end
    endcase
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (in_acc && is_append && !full) begin
      vtx_mem[cnt_r[ADDR_W-1:0]] <= {in_coord_x, in_coord_y};
    end
    if (rd_en) begin
      rd_data_r <= vtx_mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_r.vld  <= rd_en;
      rd_r.seed <= rd_seed;
      if (in_acc && is_clear) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (in_acc && is_append) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk bookkeeping and result payload
  always_ff @(posedge clk) begin
    if (in_acc && is_test) begin
      px_r     <= in_coord_x;
      py_r     <= in_coord_y;
      idx_r    <= '0;
      last_r   <= seed_addr;
      inside_r <= 1'b0;
    end else begin
      if (state_r == ST_WALK) begin
        idx_r <= idx_r + ADDR_W'(1);
      end
      if (edge_stat.flip) begin
        inside_r <= ~inside_r;
      end
    end
    if (out_load) begin
      out_inside_r <= inside_r;
      out_ovf_r    <= ovf_r;
      out_held_r   <= HELD_W'(cnt_r);
    end
  end

  pip_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .rd    (rd_r),
    .vtx_x ($signed(rd_data_r[WORD_W-1:COORD_W])),
    .vtx_y ($signed(rd_data_r[COORD_W-1:0])),
    .pt_x  (px_r),
    .pt_y  (py_r),
    .stat  (edge_stat)
  );

  assign out_valid           = out_valid_r;
  assign out_inside_res      = out_inside_r;
  assign out_vertex_overflow = out_ovf_r;
  assign out_vertices_held   = out_held_r;

endmodule

`default_nettype wire

// File: sv/pip_chk.sv
// Port-level checker for point_in_polygon_test, attached by bind.
// Depends on pip_pkg.
`default_nettype none

module pip_chk
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = PIP_MAX_VERTICES_DEF
)(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic [ACT_W-1:0]          in_action,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_inside_res,
  input wire logic                      out_vertex_overflow,
  input wire logic [HELD_W-1:0]         out_vertices_held
);

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside_res)
      && $stable(out_vertex_overflow) && $stable(out_vertices_held))
    else $error("stalled result changed");

  // A test keeps the input closed in the cycle after it is taken
  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_TEST |=> !in_ready)
    else $error("input taken right after a test");

  // Clear and append finish at once
  a_edit_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_CLEAR || in_action == ACT_APPEND)
      |=> in_ready)
    else $error("clear or append stalled the input");

  // Overflow only once the polygon is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_vertex_overflow |-> out_vertices_held == HELD_W'(MAX_VERTICES))
    else $error("overflow reported below capacity");

endmodule

bind point_in_polygon_test pip_chk #(.MAX_VERTICES(MAX_VERTICES)) u_pip_chk (.*);

`default_nettype wire
